// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_DEN = 2'd1,
      ST_DIV_0   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_SUM,
      S_GCD_INIT,
      S_GCD,
      S_DIV_INIT,
      S_DIV,
      S_DONE
   } state_type;

   localparam int RESULT_NUM_WIDTH = 33;
   localparam int RESULT_DEN_WIDTH = 31;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic sum;
      logic gcd_init;
      logic gcd_step;
      logic div_init;
      logic div_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic special;
      logic num_zero;
      logic gcd_done;
      logic div_done;
   } sts_type;

endpackage

// ===== rtl/rau_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer for products, sum, gcd and reduction
// ----------------------------------------------------------------------------
module rau_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             out_free,
   input  rau_pkg::sts_type sts,
   output rau_pkg::cmd_type cmd,
   output logic             busy,
   output logic             finish
);

   rau_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      finish   = 1'b0;
      busy     = (state_ff != rau_pkg::S_IDLE);
      case (state_ff)
         rau_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = rau_pkg::S_MUL;
            end
         end
         rau_pkg::S_MUL: begin
            if (sts.special) begin
               state_in = rau_pkg::S_DONE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = rau_pkg::S_SUM;
            end
         end
         rau_pkg::S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = rau_pkg::S_GCD_INIT;
         end
         rau_pkg::S_GCD_INIT: begin
            if (sts.num_zero) begin
               state_in = rau_pkg::S_DONE;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = rau_pkg::S_GCD;
            end
         end
         rau_pkg::S_GCD: begin
            if (sts.gcd_done) begin
               state_in = rau_pkg::S_DIV_INIT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         rau_pkg::S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = rau_pkg::S_DIV;
         end
         rau_pkg::S_DIV: begin
            if (sts.div_done) begin
               state_in = rau_pkg::S_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         rau_pkg::S_DONE: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = rau_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rau_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/rau_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_dpath
// cross products, signed sum, binary gcd and restoring division by the gcd
// ----------------------------------------------------------------------------
module rau_dpath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic [1:0]                            operation,
   input  logic [OPERAND_WIDTH-1:0]              a_num,
   input  logic [OPERAND_WIDTH-1:0]              a_den,
   input  logic [OPERAND_WIDTH-1:0]              b_num,
   input  logic [OPERAND_WIDTH-1:0]              b_den,
   input  rau_pkg::cmd_type                      cmd,
   output rau_pkg::sts_type                      sts,
   output logic [rau_pkg::RESULT_NUM_WIDTH-1:0]  result_num,
   output logic [rau_pkg::RESULT_DEN_WIDTH-1:0]  result_den,
   output logic [1:0]                            status
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int SW = PW + 1;
   localparam int CW = $clog2(SW + 1);
   localparam int KW = $clog2(SW + 2);

   logic [1:0]   op_ff;
   logic [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic         an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff;
   logic [PW-1:0] p1_ff, p2_ff, p3_ff;
   logic          p1_s_ff, p2_s_ff, p3_s_ff;
   logic [SW-1:0] num_ff, den_ff;
   logic          neg_ff;
   logic [SW-1:0] gx_ff, gy_ff;
   logic [KW-1:0] shift_ff;
   logic [SW-1:0] q_ff, r_ff, dvs_ff;
   logic          phase_ff;
   logic [CW-1:0] cnt_ff;
   logic [SW-1:0] qn_ff;
   logic [1:0]    stat_ff;

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   logic special;
   assign special = (ad_ff == '0) || (bd_ff == '0) ||
                    ((op_ff == rau_pkg::OP_DIV) && (bn_ff == '0));

   // signed sum of the first two products
   logic [SW-1:0] e1, e2, diff;
   logic          t2_s;
   assign e1   = {1'b0, p1_ff};
   assign e2   = {1'b0, p2_ff};
   assign t2_s = p2_s_ff ^ (op_ff == rau_pkg::OP_SUB);
   assign diff = (e1 >= e2) ? (e1 - e2) : (e2 - e1);

   // binary gcd step
   logic [SW-1:0] gdif;
   assign gdif = (gx_ff > gy_ff) ? (gx_ff - gy_ff) : (gy_ff - gx_ff);

   // restoring division step
   logic [SW:0] trial;
   assign trial = {r_ff, q_ff[SW-1]} - {1'b0, dvs_ff};
   logic [SW-1:0] q_next, r_next;
   assign r_next = trial[SW] ? {r_ff[SW-2:0], q_ff[SW-1]} : trial[SW-1:0];
   assign q_next = {q_ff[SW-2:0], !trial[SW]};

   logic [SW-1:0] gcd_val;
   assign gcd_val = gx_ff << shift_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= operation;
         an_ff   <= mag(a_num);  an_s_ff <= a_num[W-1];
         ad_ff   <= mag(a_den);  ad_s_ff <= a_den[W-1];
         bn_ff   <= mag(b_num);  bn_s_ff <= b_num[W-1];
         bd_ff   <= mag(b_den);  bd_s_ff <= b_den[W-1];
      end
      if (cmd.load) begin
         stat_ff <= rau_pkg::ST_OK;
         num_ff  <= '0;
      end else if (special) begin
         stat_ff <= ((ad_ff == '0) || (bd_ff == '0)) ? rau_pkg::ST_BAD_DEN
                                                     : rau_pkg::ST_DIV_0;
      end
      if (cmd.mul) begin
         case (op_ff)
            rau_pkg::OP_MUL: begin
               p1_ff <= PW'(an_ff) * PW'(bn_ff);  p1_s_ff <= an_s_ff ^ bn_s_ff;
               p2_ff <= '0;                       p2_s_ff <= 1'b0;
               p3_ff <= PW'(ad_ff) * PW'(bd_ff);  p3_s_ff <= ad_s_ff ^ bd_s_ff;
            end
            rau_pkg::OP_DIV: begin
               p1_ff <= PW'(an_ff) * PW'(bd_ff);  p1_s_ff <= an_s_ff ^ bd_s_ff;
               p2_ff <= '0;                       p2_s_ff <= 1'b0;
               p3_ff <= PW'(ad_ff) * PW'(bn_ff);  p3_s_ff <= ad_s_ff ^ bn_s_ff;
            end
            default: begin
               p1_ff <= PW'(an_ff) * PW'(bd_ff);  p1_s_ff <= an_s_ff ^ bd_s_ff;
               p2_ff <= PW'(bn_ff) * PW'(ad_ff);  p2_s_ff <= bn_s_ff ^ ad_s_ff;
               p3_ff <= PW'(ad_ff) * PW'(bd_ff);  p3_s_ff <= ad_s_ff ^ bd_s_ff;
            end
         endcase
      end
      if (cmd.sum) begin
         den_ff <= {1'b0, p3_ff};
         if ((op_ff == rau_pkg::OP_MUL) || (op_ff == rau_pkg::OP_DIV) ||
             (p1_s_ff == t2_s)) begin
            num_ff <= e1 + e2;
            neg_ff <= p1_s_ff ^ p3_s_ff;
         end else begin
            num_ff <= diff;
            neg_ff <= ((e1 >= e2) ? p1_s_ff : t2_s) ^ p3_s_ff;
         end
      end
      if (cmd.gcd_init) begin
         gx_ff    <= num_ff;
         gy_ff    <= den_ff;
         shift_ff <= '0;
      end else if (cmd.gcd_step) begin
         if (!gx_ff[0] && !gy_ff[0]) begin
            gx_ff    <= gx_ff >> 1;
            gy_ff    <= gy_ff >> 1;
            shift_ff <= shift_ff + 1'b1;
         end else if (!gx_ff[0]) begin
            gx_ff <= gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_ff <= gy_ff >> 1;
         end else begin
            gx_ff <= (gx_ff < gy_ff) ? gx_ff : gy_ff;
            gy_ff <= gdif;
         end
      end
      if (cmd.div_init) begin
         q_ff     <= num_ff;
         r_ff     <= '0;
         dvs_ff   <= gcd_val;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end else if (cmd.load) begin
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end else if (cmd.div_step) begin
         if (cnt_ff != CW'(SW - 1)) begin
            r_ff   <= r_next;
            q_ff   <= q_next;
            cnt_ff <= cnt_ff + 1'b1;
         end else if (!phase_ff) begin
            // numerator quotient done, start on the denominator
            cnt_ff   <= '0;
            phase_ff <= 1'b1;
            qn_ff    <= q_next;
            q_ff     <= den_ff;
            r_ff     <= '0;
         end else begin
            cnt_ff   <= '0;
            phase_ff <= 1'b0;
            r_ff     <= r_next;
            q_ff     <= q_next;
            num_ff   <= qn_ff;
            den_ff   <= q_next;
         end
      end
   end

   logic div_last;
   assign div_last = cmd.div_step && phase_ff && (cnt_ff == CW'(SW - 1));
   logic div_done_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_init || cmd.load) begin
         div_done_ff <= 1'b0;
      end else if (div_last) begin
         div_done_ff <= 1'b1;
      end
   end

   assign sts.special  = special;
   assign sts.num_zero = (num_ff == '0);
   assign sts.gcd_done = (gy_ff == '0);
   assign sts.div_done = div_done_ff;

   // final sign and field masking; zero and error cases give 0/1
   logic [SW:0] signed_num;
   assign signed_num = neg_ff ? -{1'b0, num_ff} : {1'b0, num_ff};
   logic zero_out;
   assign zero_out = (stat_ff != rau_pkg::ST_OK) || (num_ff == '0);

   always_comb begin
      result_num = '0;
      result_den = rau_pkg::RESULT_DEN_WIDTH'(1);
      if (!zero_out) begin
         for (int i = 0; i < rau_pkg::RESULT_NUM_WIDTH; i++) begin
            result_num[i] = (i <= SW) ? signed_num[(i <= SW) ? i : 0] : signed_num[SW];
         end
         for (int i = 0; i < rau_pkg::RESULT_DEN_WIDTH; i++) begin
            result_den[i] = (i < SW) ? den_ff[(i < SW) ? i : 0] : 1'b0;
         end
      end
   end
   assign status = stat_ff;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// exact add, subtract, multiply or divide of two fractions with gcd reduction
// ----------------------------------------------------------------------------
// One transaction carries an operation and two fractions a_num/a_den and
// b_num/b_den; one result transaction returns the reduced fraction with a
// positive denominator and a status (zero denominator, division by zero).
// Items are handled one at a time. An item passes through states for products,
// sum and zero check, then a binary gcd loop, a divider setup state, then two
// restoring divisions by the gcd, and a state that hands the result to the
// output register; the iterative gcd and divider take most of the time from
// acceptance to a valid result. Error results go from the product state
// straight to the hand-over, and zero results do so after the zero check. A
// new transaction is taken in the cycle after the result is handed over. The
// result sits in an output register, so a stalled result does not lose data.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // operation[1:0], a_num, a_den, b_num, b_den, zero fill
   input  logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // result_num[32:0], result_den[63:33], status[65:64], zero fill
   output logic [71:0]                    rsp_tdata
);

   localparam int W = OPERAND_WIDTH;

   rau_pkg::cmd_type cmd;
   rau_pkg::sts_type sts;
   logic busy, finish;
   logic [rau_pkg::RESULT_NUM_WIDTH-1:0] res_num;
   logic [rau_pkg::RESULT_DEN_WIDTH-1:0] res_den;
   logic [1:0] res_stat;

   logic        out_valid_ff;
   logic [71:0] out_data_ff;

   // a new transaction is taken only while the sequencer is idle
   assign req_tready = !busy;

   rau_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid && req_tready),
      .out_free (!out_valid_ff || rsp_tready),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy),
      .finish   (finish)
   );

   rau_dpath #(.OPERAND_WIDTH(W)) u_dpath (
      .clock      (clock),
      .operation  (req_tdata[1:0]),
      .a_num      (req_tdata[2 +: W]),
      .a_den      (req_tdata[2+W +: W]),
      .b_num      (req_tdata[2+2*W +: W]),
      .b_den      (req_tdata[2+3*W +: W]),
      .cmd        (cmd),
      .sts        (sts),
      .result_num (res_num),
      .result_den (res_den),
      .status     (res_stat)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         out_data_ff <= {6'd0, res_stat, res_den, res_num};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // no new input while a computation is under way
   assert property (@(posedge clock) disable iff (reset) busy |-> !req_tready)
      else $error("input accepted while busy");

   // a finished result never overwrites one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      finish |-> (!out_valid_ff || rsp_tready))
      else $error("result overwritten");

   // the reported status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[65:64] != 2'd3))
      else $error("bad status code");

endmodule

// ===== verif/rau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// predicts and compares the results of the rational arithmetic unit
// ----------------------------------------------------------------------------
// Watches both channels. Each accepted request is turned into the expected
// reduced fraction and status, which wait in a queue until the matching
// response transaction arrives.
module rau_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   output int          error_count,
   output int          pending_count
);

   // laid out as on rsp_tdata, numerator in the lowest bits
   typedef struct packed {
      rau_pkg::status_type status;
      logic [30:0]         den;
      logic [32:0]         num;
   } fraction_type;

   fraction_type reduced_q[$];

   function automatic longint unsigned magnitude(logic [15:0] v);
      return v[15] ? longint'(17'h10000 - v) : longint'(v);
   endfunction

   function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic fraction_type reduce_fraction(logic [71:0] d);
      fraction_type r;
      rau_pkg::op_type op;
      logic [15:0] an, ad, bn, bd;
      longint unsigned nm, dm, p1, p2, g;
      logic nneg, dneg, s1, s2;
      longint unsigned n;
      op = rau_pkg::op_type'(d[1:0]);
      an = d[17:2];
      ad = d[33:18];
      bn = d[49:34];
      bd = d[65:50];
      r.num = '0;
      r.den = 31'd1;
      r.status = rau_pkg::ST_OK;
      if (ad == 0 || bd == 0) begin
         r.status = rau_pkg::ST_BAD_DEN;
         return r;
      end
      if (op == rau_pkg::OP_DIV && bn == 0) begin
         r.status = rau_pkg::ST_DIV_0;
         return r;
      end
      case (op)
         rau_pkg::OP_MUL: begin
            nm = magnitude(an) * magnitude(bn); nneg = an[15] ^ bn[15];
            dm = magnitude(ad) * magnitude(bd); dneg = ad[15] ^ bd[15];
         end
         rau_pkg::OP_DIV: begin
            nm = magnitude(an) * magnitude(bd); nneg = an[15] ^ bd[15];
            dm = magnitude(ad) * magnitude(bn); dneg = ad[15] ^ bn[15];
         end
         default: begin
            p1 = magnitude(an) * magnitude(bd); s1 = an[15] ^ bd[15];
            p2 = magnitude(bn) * magnitude(ad); s2 = bn[15] ^ ad[15];
            if (op == rau_pkg::OP_SUB) s2 = !s2;
            if (s1 == s2) begin
               nm = p1 + p2; nneg = s1;
            end else if (p1 >= p2) begin
               nm = p1 - p2; nneg = s1;
            end else begin
               nm = p2 - p1; nneg = s2;
            end
            dm = magnitude(ad) * magnitude(bd); dneg = ad[15] ^ bd[15];
         end
      endcase
      if (nm == 0) return r;
      g = gcd_of(nm, dm);
      n = nm / g;
      if (nneg != dneg) n = -n;
      r.num = n[32:0];
      r.den = 31'(dm / g);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   assign pending_count = reduced_q.size();

   always @(posedge clock) begin
      fraction_type want, got;
      if (reset) begin
         error_count = 0;
      end else begin
         if (req_tvalid && req_tready) reduced_q.push_back(reduce_fraction(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[65:0];
            if (reduced_q.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = reduced_q.pop_front();
               if (got.num !== want.num)
                  report_mismatch("result_num", $signed(got.num), $signed(want.num));
               if (got.den !== want.den) report_mismatch("result_den", got.den, want.den);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
            end
         end
      end
   end

endmodule

// ===== verif/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// stimulus and verdict for the rational arithmetic unit
// ----------------------------------------------------------------------------
// Sends directed corner fractions for every operation, then random ones
// under three idling mixes, a long response hold-off and a drain pause.
module tb_rational_arithmetic_unit;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   int          error_count, pending_count;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   logic        hold_off = 1'b0;
   int          quiet_cycles = 0;

   localparam int QUIET_LIMIT = 20000;

   rational_arithmetic_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   rau_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, or a hard hold-off while hold_off is set
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [15:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(8)) - 4);
         4, 5: return 16'(int'($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // one request transaction; gaps come before the offer, valid stays up
   // after acceptance until the next gap or drain
   task automatic send_item(rau_pkg::op_type op, logic [15:0] an, logic [15:0] ad,
                            logic [15:0] bn, logic [15:0] bd);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, bd, bn, ad, an, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(int count);
      logic [15:0] ad, bd;
      repeat (count) begin
         ad = pick_value();
         bd = pick_value();
         // keep zero denominators rare so most items reach the gcd path
         if ($urandom_range(19) != 0 && ad == 0) ad = 16'd1;
         if ($urandom_range(19) != 0 && bd == 0) bd = 16'd7;
         send_item(rau_pkg::op_type'($urandom_range(3)), pick_value(), ad, pick_value(), bd);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      rau_pkg::op_type op;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners for every operation
      for (int k = 0; k < 4; k++) begin
         op = rau_pkg::op_type'(k);
         send_item(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
         send_item(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
         send_item(op, 16'd3, 16'd0, 16'd1, 16'd2);
         send_item(op, 16'hffff, 16'hfffe, 16'd0, 16'h0003);
         send_item(op, 16'd2, 16'd4, 16'd2, 16'd4);
      end
      send_item(rau_pkg::OP_DIV, 16'd1, 16'd0, 16'd0, 16'd1);
      send_item(rau_pkg::OP_ADD, 16'd5, 16'd1, 16'd1, 16'd0);
      send_item(rau_pkg::OP_SUB, 16'h7fff, 16'h0001, 16'h7fff, 16'h0001);

      send_idle_pct = 29; recv_idle_pct = 49;
      send_random(600);
      send_idle_pct = 49; recv_idle_pct = 29;
      send_random(600);

      // sender pauses until every expected result is back
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      fork
         begin
            hold_off <= 1'b1;
            repeat (2000) @(posedge clock);
            hold_off <= 1'b0;
         end
         send_random(20);
      join
      send_random(610);

      drain();
      repeat (400) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dpath.sv
rtl/rational_arithmetic_unit.sv
verif/rau_checker.sv
verif/tb_rational_arithmetic_unit.sv
